FILE: hw/rtl/lcs_pkg.sv
package lcs_pkg;

  localparam int MAX_LEN = 64;
  localparam int SYM_W = 16;
  localparam int LEN_W = 7;
  localparam int LEN_CAP = 127;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int RUN_W = $clog2(MAX_LEN + 1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_COMPARE = 1'b1;

  typedef struct packed {
    logic load;
    logic compare;
    logic last;
  } lcs_cmd_t;

endpackage

FILE: hw/rtl/lcs_ctrl.sv
module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lcs_cmd_t cmd
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state_r;
  logic   accept;
  logic   emit;

  assign out_valid = (state_r == ST_FULL);
  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign emit = accept && (in_action == ACT_COMPARE) && in_last;

  always_comb begin
    cmd.load = accept && (in_action == ACT_LOAD);
    cmd.compare = accept && (in_action == ACT_COMPARE);
    cmd.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      unique case (state_r)
        ST_EMPTY: begin
          if (emit) begin
            state_r <= ST_FULL;
          end
        end
        ST_FULL: begin
          if (out_ready && !emit) begin
            state_r <= ST_EMPTY;
          end
        end
        default: begin
          state_r <= ST_EMPTY;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/lcs_dpath.sv
module lcs_dpath
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lcs_cmd_t         cmd,
  input  logic [SYM_W-1:0] symbol,
  output logic [LEN_W-1:0] longest_length,
  output logic             reference_truncated
);

  logic [SYM_W-1:0] units_r [MAX_LEN];
  logic [RUN_W-1:0] run_r [MAX_LEN];
  logic [RUN_W-1:0] run_cmp [MAX_LEN];
  logic [RUN_W-1:0] prev_run [MAX_LEN];
  logic [MAX_LEN-1:0] hit;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_base;
  logic [RUN_W-1:0] best_r;
  logic [RUN_W-1:0] best_nxt;
  logic             done_r;
  logic             trunc_r;
  logic             fresh;
  logic             room;
  logic             wr_en;
  logic [LEN_W-1:0] out_len_r;
  logic             out_trunc_r;

  assign fresh = cmd.load && done_r;
  assign count_base = fresh ? '0 : count_r;
  assign room = count_base < CNT_W'(MAX_LEN);
  assign wr_en = cmd.load && room;

  // Each cell extends the diagonal run of its left neighbor on a match.
  always_comb begin
    for (int k = 0; k < MAX_LEN; k++) begin
      prev_run[k] = (k == 0) ? '0 : run_r[(k == 0) ? 0 : k - 1];
    end
    for (int k = 0; k < MAX_LEN; k++) begin
      logic match;
      match = (CNT_W'(k) < count_r) && (units_r[k] == symbol);
      run_cmp[k] = match ? prev_run[k] + RUN_W'(1) : '0;
      hit[k] = match && (prev_run[k] == best_r);
    end
  end

  // A run grows by at most one per word, so the best run does too.
  assign best_nxt = best_r + RUN_W'(hit != '0);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_LEN; k++) begin
      if (wr_en && (CNT_W'(k) == count_base)) begin
        units_r[k] <= symbol;
      end
    end
    if (cmd.compare && cmd.last) begin
      out_len_r <= (32'(best_nxt) > 32'(LEN_CAP)) ? LEN_W'(LEN_CAP) : LEN_W'(best_nxt);
      out_trunc_r <= trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      best_r <= '0;
      done_r <= 1'b1;
      trunc_r <= 1'b0;
      for (int k = 0; k < MAX_LEN; k++) begin
        run_r[k] <= '0;
      end
    end else if (cmd.load) begin
      if (fresh) begin
        best_r <= '0;
        for (int k = 0; k < MAX_LEN; k++) begin
          run_r[k] <= '0;
        end
      end
      count_r <= room ? count_base + CNT_W'(1) : count_base;
      trunc_r <= fresh ? 1'b0 : (trunc_r || !room);
      done_r <= cmd.last;
    end else if (cmd.compare) begin
      done_r <= 1'b1;
      if (cmd.last) begin
        best_r <= '0;
        for (int k = 0; k < MAX_LEN; k++) begin
          run_r[k] <= '0;
        end
      end else begin
        best_r <= best_nxt;
        for (int k = 0; k < MAX_LEN; k++) begin
          run_r[k] <= run_cmp[k];
        end
      end
    end
  end

  assign longest_length = out_len_r;
  assign reference_truncated = out_trunc_r;

endmodule

FILE: hw/rtl/longest_common_substring_length_top.sv
// Channel   Ports                                            Direction
// in        in_valid, in_ready, in_action, in_symbol, in_last  input words
// out       out_valid, out_ready, out_longest_length,          result words
//           out_reference_truncated
//
// All reference cells compare and update their run counters in parallel for each
// word, and the best run moves by at most one per word.
// A result appears in the cycle after the compare word marked last is taken.
// Reset is synchronous and active low and needs no clearing pass.
// A word is taken whenever the result register is empty or being drained.
module longest_common_substring_length_top
  import lcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LEN_W-1:0] out_longest_length,
  output logic             out_reference_truncated
);

  lcs_cmd_t cmd;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lcs_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .symbol              (in_symbol),
    .longest_length      (out_longest_length),
    .reference_truncated (out_reference_truncated)
  );

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_action == ACT_COMPARE) && in_last))
    else $error("result appeared without a final compare word");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_action == ACT_LOAD)) |=> !out_valid)
    else $error("load word produced a result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while result path free");

  a_length_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_longest_length) <= MAX_LEN))
    else $error("result length exceeds reference capacity");

endmodule

FILE: bench/tb_longest_common_substring_length_top.sv
module tb_longest_common_substring_length_top;
  import lcs_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_LIMIT = 1000;
  localparam int TARGET_WORDS = 450;
  localparam int IDLE_PCT = 37;
  localparam int ROW_COUNT = 25;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic truncated;
  } lcs_result_t;

  typedef struct packed {
    logic action;
    logic [SYM_W-1:0] symbol;
    logic last;
    logic [7:0] reps;
    logic pinned;
    logic [LEN_W-1:0] length;
    logic truncated;
  } word_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = ACT_LOAD;
  logic [SYM_W-1:0] in_symbol = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LEN_W-1:0] out_longest_length;
  logic out_reference_truncated;

  lcs_result_t awaited_results[$];
  int mismatches = 0;
  int words_taken = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  logic [SYM_W-1:0] ref_units [MAX_LEN];
  int ref_count = 0;
  int run_len [MAX_LEN];
  int best_run = 0;
  bit ref_done = 1'b1;
  bit trunc_flag = 1'b0;

  // A repeated row sends the same word reps times, with last only on the final one.
  word_row_t directed_words [ROW_COUNT] = '{
    '{ACT_COMPARE, 16'h0061, 1'b1, 8'd1,  1'b1, 7'd0,  1'b0},
    '{ACT_LOAD,    16'h0000, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_LOAD,    16'hFFFF, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0000, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'hFFFF, 1'b1, 8'd1,  1'b1, 7'd2,  1'b0},
    '{ACT_COMPARE, 16'hFFFE, 1'b1, 8'd1,  1'b1, 7'd0,  1'b0},
    '{ACT_LOAD,    16'h0061, 1'b1, 8'd66, 1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0061, 1'b1, 8'd70, 1'b1, 7'd64, 1'b1},
    '{ACT_COMPARE, 16'h0062, 1'b1, 8'd1,  1'b1, 7'd0,  1'b1},
    '{ACT_LOAD,    16'h0078, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_LOAD,    16'h0079, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0079, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_LOAD,    16'h007A, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0078, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h007A, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_LOAD,    16'h0061, 1'b0, 8'd2,  1'b0, 7'd0,  1'b0},
    '{ACT_LOAD,    16'h0062, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0078, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0061, 1'b0, 8'd2,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0062, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0062, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0061, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0071, 1'b0, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_LOAD,    16'h0071, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0},
    '{ACT_COMPARE, 16'h0071, 1'b1, 8'd1,  1'b0, 7'd0,  1'b0}
  };

  longest_common_substring_length_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_symbol(in_symbol),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_longest_length(out_longest_length),
    .out_reference_truncated(out_reference_truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_run_row();
    foreach (run_len[i]) run_len[i] = 0;
    best_run = 0;
  endfunction

  function automatic bit track_substring(input logic action, input logic [SYM_W-1:0] symbol,
                                         input logic last, output lcs_result_t res);
    int prev;
    int v;
    res = '0;
    if (action == ACT_LOAD) begin
      if (ref_done) begin
        ref_count = 0;
        trunc_flag = 1'b0;
        clear_run_row();
        ref_done = 1'b0;
      end
      if (ref_count < MAX_LEN) begin
        ref_units[ref_count] = symbol;
        ref_count++;
      end else begin
        trunc_flag = 1'b1;
      end
      if (last) ref_done = 1'b1;
      return 1'b0;
    end
    ref_done = 1'b1;
    // Walking downward lets each cell read its neighbor's run from before this word.
    for (int k = ref_count - 1; k >= 0; k--) begin
      if (ref_units[k] == symbol) begin
        prev = (k > 0) ? run_len[k-1] : 0;
        v = (prev + 1 > MAX_LEN) ? MAX_LEN : prev + 1;
        run_len[k] = v;
        if (v > best_run) best_run = v;
      end else begin
        run_len[k] = 0;
      end
    end
    if (!last) return 1'b0;
    res.length = LEN_W'((best_run > LEN_CAP) ? LEN_CAP : best_run);
    res.truncated = trunc_flag;
    clear_run_row();
    return 1'b1;
  endfunction

  task automatic offer_word(input logic action, input logic [SYM_W-1:0] symbol,
                            input logic last, input bit pinned, input lcs_result_t pinned_res);
    lcs_result_t res;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_symbol <= symbol;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    words_taken++;
    if (track_substring(action, symbol, last, res))
      awaited_results.push_back(pinned ? pinned_res : res);
  endtask

  task automatic wait_drained(input int bound);
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 1;
    while (awaited_results.size() != 0 && waited < bound) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin : stimulus
    logic [SYM_W-1:0] alpha [4];
    logic [SYM_W-1:0] sym;
    int n_alpha;
    int ref_len;
    int cmp_len;
    int seq;
    clear_run_row();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[r]) begin
      for (int n = 1; n <= directed_words[r].reps; n++)
        offer_word(directed_words[r].action, directed_words[r].symbol,
                   directed_words[r].last && n == directed_words[r].reps,
                   directed_words[r].pinned,
                   {directed_words[r].length, directed_words[r].truncated});
    end
    wait_drained(STALL_LIMIT * 2);

    seq = 0;
    while (words_taken < TARGET_WORDS) begin
      no_idle = (words_taken >= 180 && words_taken < 300);
      if (words_taken >= 330) hold_req = 1'b1;
      if ($urandom_range(99) < 80) begin
        n_alpha = $urandom_range(4, 2);
        for (int i = 0; i < 4; i++) alpha[i] = 16'($urandom);
        ref_len = ($urandom_range(9) == 0) ? $urandom_range(70, 50) : $urandom_range(12, 1);
        for (int i = 0; i < ref_len; i++)
          offer_word(ACT_LOAD, alpha[$urandom_range(n_alpha - 1)], i == ref_len - 1, 1'b0, '0);
        repeat ($urandom_range(3, 1)) begin
          cmp_len = $urandom_range(16, 1);
          for (int i = 0; i < cmp_len; i++) begin
            sym = ($urandom_range(7) == 0) ? 16'($urandom) : alpha[$urandom_range(n_alpha - 1)];
            offer_word(ACT_COMPARE, sym, i == cmp_len - 1, 1'b0, '0);
          end
        end
      end else begin
        repeat ($urandom_range(6, 1))
          offer_word(1'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
      end
      seq++;
      if (seq % 20 == 0) wait_drained(STALL_LIMIT * 2);
    end

    wait_drained(DRAIN_LIMIT);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", awaited_results.size()));
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("longest_common_substring_length_top regression: pass");
    end else begin
      $display("longest_common_substring_length_top regression: fail");
    end
    $finish;
  end

  initial begin : result_sink
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    lcs_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word length %0d truncated %0b",
                                  out_longest_length, out_reference_truncated));
      end else begin
        want = awaited_results.pop_front();
        if (out_longest_length !== want.length)
          report_mismatch($sformatf("longest_length %0d, expected %0d",
                                    out_longest_length, want.length));
        if (out_reference_truncated !== want.truncated)
          report_mismatch($sformatf("reference_truncated %0b, expected %0b",
                                    out_reference_truncated, want.truncated));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("longest_common_substring_length_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
